@@ rtl/salct_pkg.sv @@
// Shared types and codes for the set-associative LRU cache tracker.
`default_nettype none
package salct_pkg;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_STORE  = 2'd1,
    OP_MODIFY = 2'd2,
    OP_IFETCH = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    OC_HIT     = 2'd0,
    OC_FILL    = 2'd1,
    OC_EVICT   = 2'd2,
    OC_IGNORED = 2'd3
  } outcome_e;

  typedef enum logic [1:0] {
    CFG_SET_BITS   = 2'd0,
    CFG_BLOCK_BITS = 2'd1,
    CFG_WAYS       = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    BK_IDLE,
    BK_LOOK
  } back_state_e;

  localparam int unsigned AddrFieldW = 64;

  typedef struct packed {
    op_e                   operation;
    logic [AddrFieldW-1:0] address;
  } in_req_t;

  typedef struct packed {
    outcome_e    outcome;
    logic        second_hit;
    logic [31:0] hit_total;
    logic [31:0] miss_total;
    logic [31:0] eviction_total;
  } out_rsp_t;

  typedef struct packed {
    logic [2:0] set_bits;
    logic [3:0] block_bits;
    logic [3:0] ways_in_use;
  } cfg_t;

endpackage
`default_nettype wire

@@ rtl/salct_front.sv @@
// Front end: splits the address into set and tag and queues the access.
`default_nettype none
module salct_front
  import salct_pkg::*;
#(
  parameter int unsigned MAX_SETS   = 64,
  parameter int unsigned ADDR_WIDTH = 64,
  parameter int unsigned SET_W      = 6
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire cfg_t             cfg_i,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire in_req_t          in_data_i,
  output logic                  q_valid_o,
  input  wire logic             q_pop_i,
  output op_e                   q_op_o,
  output logic [SET_W-1:0]      q_set_o,
  output logic [ADDR_WIDTH-1:0] q_tag_o
);

  localparam int unsigned SetLim = $clog2(MAX_SETS + 1) - 1;
  localparam logic [AddrFieldW-1:0] AddrMask =
    (ADDR_WIDTH >= AddrFieldW) ? '1 : ((AddrFieldW'(1) << ADDR_WIDTH) - AddrFieldW'(1));

  logic [AddrFieldW-1:0] addr;
  logic [2:0]            s_eff;
  logic [AddrFieldW-1:0] set_full;
  logic [4:0]            tag_sh;
  logic [AddrFieldW-1:0] tag_full;

  always_comb begin
    addr     = in_data_i.address & AddrMask;
    s_eff    = (32'(cfg_i.set_bits) > SetLim) ? 3'(SetLim) : cfg_i.set_bits;
    set_full = (addr >> cfg_i.block_bits) & ((AddrFieldW'(1) << s_eff) - AddrFieldW'(1));
    tag_sh   = 5'(cfg_i.block_bits) + 5'(s_eff);
    tag_full = addr >> tag_sh;
  end

  // two-entry queue
  op_e                   op_q  [2];
  logic [SET_W-1:0]      set_q [2];
  logic [ADDR_WIDTH-1:0] tag_q [2];
  logic                  wp_q, rp_q;
  logic [1:0]            cnt_q;
  logic                  push;

  assign in_ready_o = (cnt_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_op_o     = op_q[rp_q];
  assign q_set_o    = set_q[rp_q];
  assign q_tag_o    = tag_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      op_q[wp_q]  <= in_data_i.operation;
      set_q[wp_q] <= set_full[SET_W-1:0];
      tag_q[wp_q] <= tag_full[ADDR_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (q_pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(q_pop_i);
    end
  end

endmodule
`default_nettype wire

@@ rtl/salct_back.sv @@
// Back end: reads the set row, looks up the tag, updates LRU ranks and totals.
`default_nettype none
module salct_back
  import salct_pkg::*;
#(
  parameter int unsigned MAX_SETS   = 64,
  parameter int unsigned MAX_WAYS   = 8,
  parameter int unsigned ADDR_WIDTH = 64,
  parameter int unsigned SET_W      = 6
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire cfg_t             cfg_i,
  input  wire logic             q_valid_i,
  output logic                  q_pop_o,
  input  wire op_e              q_op_i,
  input  wire logic [SET_W-1:0] q_set_i,
  input  wire logic [ADDR_WIDTH-1:0] q_tag_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output out_rsp_t              out_data_o
);

  localparam int unsigned AW  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int unsigned WCW = $clog2(MAX_WAYS + 1);
  localparam logic [AW-1:0] AgeMax = AW'(MAX_WAYS - 1);

  // set rows: one row per set, every way side by side
  logic [MAX_WAYS-1:0]            mv_mem [MAX_SETS];
  logic [MAX_WAYS*ADDR_WIDTH-1:0] mt_mem [MAX_SETS];
  logic [MAX_WAYS*AW-1:0]         ma_mem [MAX_SETS];
  logic [MAX_SETS-1:0]            row_wr_q;

  logic [MAX_WAYS-1:0]            rv_q;
  logic [MAX_WAYS*ADDR_WIDTH-1:0] rt_q;
  logic [MAX_WAYS*AW-1:0]         ra_q;
  logic                           rfresh_q;

  back_state_e           state_q, state_d;
  op_e                   op_q;
  logic [SET_W-1:0]      set_q;
  logic [ADDR_WIDTH-1:0] tag_q;
  logic                  out_valid_q;
  out_rsp_t              out_q;
  logic [31:0]           hits_q, miss_q, evict_q;

  logic issue, slot_free, wr_en;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    state_d = state_q;
    issue   = 1'b0;
    unique case (state_q)
      BK_IDLE: begin
        if (q_valid_i && slot_free) begin
          issue   = 1'b1;
          state_d = BK_LOOK;
        end
      end
      BK_LOOK: state_d = BK_IDLE;
      default: state_d = BK_IDLE;
    endcase
  end
  assign q_pop_o = issue;

  always_ff @(posedge clk_i) begin
    if (issue) begin
      rv_q  <= mv_mem[q_set_i];
      rt_q  <= mt_mem[q_set_i];
      ra_q  <= ma_mem[q_set_i];
      op_q  <= q_op_i;
      set_q <= q_set_i;
      tag_q <= q_tag_i;
    end
  end

  // lookup
  logic [WCW-1:0]        ways;
  logic [MAX_WAYS-1:0]   v, nv;
  logic [ADDR_WIDTH-1:0] t  [MAX_WAYS];
  logic [ADDR_WIDTH-1:0] nt [MAX_WAYS];
  logic [AW-1:0]         a  [MAX_WAYS];
  logic [AW-1:0]         na [MAX_WAYS];
  logic                  hit, has_free;
  logic [AW-1:0]         hit_w, free_w, vic_w, sel_w, sel_a;
  outcome_e              oc;
  logic [1:0]            hinc;
  logic [32:0]           hsum;
  logic [31:0]           hits_d, miss_d, evict_d;
  logic [MAX_WAYS*ADDR_WIDTH-1:0] wt;
  logic [MAX_WAYS*AW-1:0]         wa;

  always_comb begin
    if (cfg_i.ways_in_use == 4'd0) ways = WCW'(1);
    else if (32'(cfg_i.ways_in_use) > MAX_WAYS) ways = WCW'(MAX_WAYS);
    else ways = WCW'(cfg_i.ways_in_use);

    for (int i = 0; i < MAX_WAYS; i++) begin
      v[i] = rfresh_q && rv_q[i];
      t[i] = rfresh_q ? rt_q[i*ADDR_WIDTH +: ADDR_WIDTH] : '0;
      a[i] = rfresh_q ? ra_q[i*AW +: AW] : '0;
    end

    hit = 1'b0; hit_w = '0; has_free = 1'b0; free_w = '0; vic_w = '0;
    for (int i = MAX_WAYS - 1; i >= 0; i--) begin
      if (WCW'(i) < ways) begin
        if (v[i] && t[i] == tag_q) begin
          hit   = 1'b1;
          hit_w = AW'(i);
        end
        if (!v[i]) begin
          has_free = 1'b1;
          free_w   = AW'(i);
        end
      end
    end
    for (int i = 1; i < MAX_WAYS; i++) begin
      if (WCW'(i) < ways && a[i] > a[vic_w]) vic_w = AW'(i);
    end

    sel_w = hit ? hit_w : vic_w;
    sel_a = a[sel_w];
    nv = v;
    for (int i = 0; i < MAX_WAYS; i++) begin
      nt[i] = t[i];
      na[i] = a[i];
    end
    if (!hit && has_free) begin
      oc = OC_FILL;
      for (int i = 0; i < MAX_WAYS; i++) begin
        if (WCW'(i) < ways && v[i] && a[i] < AgeMax) na[i] = a[i] + AW'(1);
      end
      nv[free_w] = 1'b1;
      nt[free_w] = tag_q;
      na[free_w] = '0;
    end else begin
      oc = hit ? OC_HIT : OC_EVICT;
      for (int i = 0; i < MAX_WAYS; i++) begin
        if (WCW'(i) < ways && AW'(i) != sel_w && v[i] && a[i] < sel_a)
          na[i] = a[i] + AW'(1);
      end
      nt[sel_w] = tag_q;
      na[sel_w] = '0;
    end
    for (int i = 0; i < MAX_WAYS; i++) begin
      wt[i*ADDR_WIDTH +: ADDR_WIDTH] = nt[i];
      wa[i*AW +: AW] = na[i];
    end

    // the second access of a modify always hits the line just touched
    hinc = 2'(hit) + 2'(op_q == OP_MODIFY);
    hsum = {1'b0, hits_q} + 33'(hinc);
    hits_d  = hsum[32] ? '1 : hsum[31:0];
    miss_d  = (!hit && miss_q != '1) ? miss_q + 32'd1 : miss_q;
    evict_d = (oc == OC_EVICT && evict_q != '1) ? evict_q + 32'd1 : evict_q;
    wr_en   = (state_q == BK_LOOK) && (op_q != OP_IFETCH);
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mv_mem[set_q] <= nv;
      mt_mem[set_q] <= wt;
      ma_mem[set_q] <= wa;
    end
    if (state_q == BK_LOOK) begin
      if (op_q == OP_IFETCH) begin
        out_q.outcome    <= OC_IGNORED;
        out_q.second_hit <= 1'b0;
      end else begin
        out_q.outcome    <= oc;
        out_q.second_hit <= (op_q == OP_MODIFY);
      end
      out_q.hit_total      <= wr_en ? hits_d : hits_q;
      out_q.miss_total     <= wr_en ? miss_d : miss_q;
      out_q.eviction_total <= wr_en ? evict_d : evict_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
      row_wr_q    <= '0;
      rfresh_q    <= 1'b0;
      hits_q      <= '0;
      miss_q      <= '0;
      evict_q     <= '0;
    end else begin
      state_q <= state_d;
      if (issue) rfresh_q <= row_wr_q[q_set_i];
      if (wr_en) begin
        row_wr_q[set_q] <= 1'b1;
        hits_q  <= hits_d;
        miss_q  <= miss_d;
        evict_q <= evict_d;
      end
      if (state_q == BK_LOOK) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

endmodule
`default_nettype wire

@@ rtl/set_assoc_lru_cache_tracker.sv @@
// Top level of the set-associative LRU cache tracker.
// Usage: send one access (operation, address) per beat on the in channel
// (in_valid_i / in_ready_o); one result beat per access leaves on the out
// channel (out_valid_o / out_ready_i) in the order taken.
// The front end splits the address into set and tag and places the access
// in a two-entry queue. The back end handles one access at a time: BK_IDLE
// reads the set row from the tag memory, and BK_LOOK compares the ways in use,
// updates LRU ranks, writes the row back and registers the result. It takes
// a new access only while the output register is free or being read. A
// modify adds a second hit to the totals in the same lookup as its first
// access. Instruction fetches pass through and report outcome 3 with totals,
// set row and LRU ranks unchanged. When the receiver stalls the result holds
// in the output register; the queue keeps taking accesses until it is full,
// then in_ready_o drops. Reset empties the queue, clears totals and marks
// every set row unwritten, so all lines read as invalid at once; no clearing
// pass is needed. The user must make configuration writes (cfg_we_i,
// cfg_idx_i, cfg_data_i) only while idle; the block does not enforce it.
`default_nettype none
module set_assoc_lru_cache_tracker
  import salct_pkg::*;
#(
  parameter int unsigned MAX_SETS   = 64,
  parameter int unsigned MAX_WAYS   = 8,
  parameter int unsigned ADDR_WIDTH = 64
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [1:0] cfg_idx_i,
  input  wire logic [3:0] cfg_data_i,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire in_req_t    in_data_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output out_rsp_t        out_data_o
);

  localparam int unsigned SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.set_bits    <= 3'd0;
      cfg_q.block_bits  <= 4'd0;
      cfg_q.ways_in_use <= 4'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SET_BITS:   cfg_q.set_bits    <= cfg_data_i[2:0];
        CFG_BLOCK_BITS: cfg_q.block_bits  <= cfg_data_i;
        CFG_WAYS:       cfg_q.ways_in_use <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic                  q_valid, q_pop;
  op_e                   q_op;
  logic [SET_W-1:0]      q_set;
  logic [ADDR_WIDTH-1:0] q_tag;

  salct_front #(
    .MAX_SETS  (MAX_SETS),
    .ADDR_WIDTH(ADDR_WIDTH),
    .SET_W     (SET_W)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .in_data_i (in_data_i),
    .q_valid_o (q_valid),
    .q_pop_i   (q_pop),
    .q_op_o    (q_op),
    .q_set_o   (q_set),
    .q_tag_o   (q_tag)
  );

  salct_back #(
    .MAX_SETS  (MAX_SETS),
    .MAX_WAYS  (MAX_WAYS),
    .ADDR_WIDTH(ADDR_WIDTH),
    .SET_W     (SET_W)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .q_valid_i  (q_valid),
    .q_pop_o    (q_pop),
    .q_op_i     (q_op),
    .q_set_i    (q_set),
    .q_tag_i    (q_tag),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

endmodule
`default_nettype wire

@@ sim/tb_top.sv @@
// Testbench for the set-associative LRU cache tracker: directed and random accesses checked by a scoreboard.
`timescale 1ns / 100ps
`default_nettype none

class cache_scoreboard;
  localparam int NSETS = 64;
  localparam int NWAYS = 8;

  bit          valid_q[NSETS*NWAYS];
  bit [63:0]   tag_q[NSETS*NWAYS];
  int unsigned age_q[NSETS*NWAYS];
  bit [31:0]   hits, misses, evicts;
  int unsigned set_bits, block_bits, ways_cfg;
  salct_pkg::out_rsp_t pending_q[$];
  int unsigned errors;

  function void clear();
    foreach (valid_q[i]) begin
      valid_q[i] = 0;
      tag_q[i] = '0;
      age_q[i] = 0;
    end
    hits = 0;
    misses = 0;
    evicts = 0;
    set_bits = 0;
    block_bits = 0;
    ways_cfg = 1;
    errors = 0;
  endfunction

  function void write_reg(salct_pkg::cfg_idx_e idx, bit [3:0] value);
    case (idx)
      salct_pkg::CFG_SET_BITS:   set_bits = value[2:0];
      salct_pkg::CFG_BLOCK_BITS: block_bits = value;
      salct_pkg::CFG_WAYS:       ways_cfg = value;
      default: ;
    endcase
  endfunction

  function bit [31:0] bump(bit [31:0] v);
    return (v == 32'hffff_ffff) ? v : v + 1;
  endfunction

  function int unsigned live_ways();
    if (ways_cfg == 0) return 1;
    if (ways_cfg > NWAYS) return NWAYS;
    return ways_cfg;
  endfunction

  function void promote(int unsigned base, int unsigned nw, int unsigned w);
    int unsigned a;
    a = age_q[base+w];
    for (int i = 0; i < nw; i++)
      if (i != w && valid_q[base+i] && age_q[base+i] < a) age_q[base+i]++;
    age_q[base+w] = 0;
  endfunction

  function salct_pkg::outcome_e lookup(int unsigned set, bit [63:0] tag);
    int unsigned nw, base, victim;
    nw = live_ways();
    base = set * NWAYS;
    for (int i = 0; i < nw; i++)
      if (valid_q[base+i] && tag_q[base+i] == tag) begin
        hits = bump(hits);
        promote(base, nw, i);
        return salct_pkg::OC_HIT;
      end
    misses = bump(misses);
    for (int i = 0; i < nw; i++)
      if (!valid_q[base+i]) begin
        for (int j = 0; j < nw; j++)
          if (valid_q[base+j] && age_q[base+j] < NWAYS - 1) age_q[base+j]++;
        valid_q[base+i] = 1;
        tag_q[base+i] = tag;
        age_q[base+i] = 0;
        return salct_pkg::OC_FILL;
      end
    evicts = bump(evicts);
    victim = 0;
    for (int i = 1; i < nw; i++)
      if (age_q[base+i] > age_q[base+victim]) victim = i;
    tag_q[base+victim] = tag;
    promote(base, nw, victim);
    return salct_pkg::OC_EVICT;
  endfunction

  function void note_access(salct_pkg::in_req_t req);
    salct_pkg::out_rsp_t r;
    int unsigned s, set;
    bit [63:0] tag;
    r.outcome = salct_pkg::OC_IGNORED;
    r.second_hit = 0;
    if (req.operation != salct_pkg::OP_IFETCH) begin
      s = (set_bits > 6) ? 6 : set_bits;
      set = (req.address >> block_bits) & ((64'd1 << s) - 1);
      tag = req.address >> (block_bits + s);
      r.outcome = lookup(set, tag);
      if (req.operation == salct_pkg::OP_MODIFY) begin
        void'(lookup(set, tag));
        r.second_hit = 1;
      end
    end
    r.hit_total = hits;
    r.miss_total = misses;
    r.eviction_total = evicts;
    pending_q.push_back(r);
  endfunction

  function void check_result(salct_pkg::out_rsp_t got);
    salct_pkg::out_rsp_t want;
    if (pending_q.size() == 0) begin
      $display("%0t unexpected result %h", $time, got);
      errors++;
      return;
    end
    want = pending_q.pop_front();
    if (got.outcome !== want.outcome || got.second_hit !== want.second_hit ||
        got.hit_total !== want.hit_total || got.miss_total !== want.miss_total ||
        got.eviction_total !== want.eviction_total) begin
      $display({"%0t mismatch: expected o=%0d s=%0d h=%0d m=%0d e=%0d, ",
                "actual o=%0d s=%0d h=%0d m=%0d e=%0d"},
               $time, want.outcome, want.second_hit, want.hit_total, want.miss_total,
               want.eviction_total, got.outcome, got.second_hit, got.hit_total,
               got.miss_total, got.eviction_total);
      errors++;
    end
  endfunction
endclass

module tb_top;
  import salct_pkg::*;

  logic     clk_i = 0;
  logic     rst_ni = 0;
  logic     cfg_we_i = 0;
  logic [1:0] cfg_idx_i = '0;
  logic [3:0] cfg_data_i = '0;
  logic     in_valid_i = 0;
  logic     in_ready_o;
  in_req_t  in_data_i = '0;
  logic     out_valid_o;
  logic     out_ready_i = 0;
  out_rsp_t out_data_o;

  cache_scoreboard sb;
  bit tail_phase = 0;
  bit stim_done = 0;
  bit long_hold = 0;
  int unsigned quiet_cycles = 0;

  set_assoc_lru_cache_tracker DUT (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  task automatic write_cfg(cfg_idx_e idx, bit [3:0] value);
    @(negedge clk_i);
    cfg_we_i <= 1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    sb.write_reg(idx, value);
    @(negedge clk_i);
    cfg_we_i <= 0;
  endtask

  task automatic wait_drained();
    while (sb.pending_q.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  // Offer one beat from a falling edge; hold until accepted.
  task automatic send_access(op_e op, bit [63:0] addr);
    if (!tail_phase && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 0;
      repeat ($urandom_range(1, 16)) @(negedge clk_i);
    end
    in_valid_i <= 1;
    in_data_i <= '{operation: op, address: addr};
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_access(in_data_i);
    @(negedge clk_i);
  endtask

  function automatic bit [63:0] rand_addr();
    return {$urandom, $urandom};
  endfunction

  // Addresses drawn from a small pool of lines so that hits and evictions occur.
  function automatic bit [63:0] pool_addr();
    bit [63:0] a;
    a = $urandom_range(0, 23);
    a = (a << (sb.block_bits + 6)) | (64'($urandom_range(0, 3)) << sb.block_bits);
    return a | ($urandom & ((64'd1 << sb.block_bits) - 1));
  endfunction

  task automatic random_phase(int n);
    int pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 9);
      send_access(op_e'($urandom_range(0, 3)), pick == 0 ? rand_addr() : pool_addr());
    end
    in_valid_i <= 0;
    wait_drained();
  endtask

  // Receiver: random stalls, one long hold-off.
  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (long_hold) begin
        out_ready_i <= 0;
        repeat (60) @(negedge clk_i);
        long_hold = 0;
      end
      if (!tail_phase && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 0;
        repeat ($urandom_range(1, 16)) @(negedge clk_i);
      end
      out_ready_i <= 1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(out_data_o);
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles > 2000) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    sb = new();
    sb.clear();
    repeat (5) @(negedge clk_i);
    rst_ni = 1;
    // Directed: defaults, one way, extremes of address and every operation.
    send_access(OP_LOAD, 64'h0);
    send_access(OP_LOAD, 64'h0);
    send_access(OP_STORE, 64'hffff_ffff_ffff_ffff);
    send_access(OP_MODIFY, 64'h0);
    send_access(OP_IFETCH, 64'h1234);
    send_access(OP_MODIFY, 64'h5555_aaaa_5555_aaaa);
    send_access(OP_LOAD, 64'haaaa_5555_aaaa_5555);
    in_valid_i <= 0;
    wait_drained();
    write_cfg(CFG_SET_BITS, 4'd7);
    write_cfg(CFG_BLOCK_BITS, 4'd12);
    write_cfg(CFG_WAYS, 4'd0);
    send_access(OP_LOAD, 64'h3f000);
    send_access(OP_LOAD, 64'h7f000);
    send_access(OP_STORE, 64'hffff_ffff_ffff_ffff);
    in_valid_i <= 0;
    wait_drained();
    write_cfg(CFG_WAYS, 4'd15);
    write_cfg(CFG_BLOCK_BITS, 4'd0);
    write_cfg(CFG_SET_BITS, 4'd0);
    // Fill one set beyond its ways to force evictions.
    for (int i = 0; i < 10; i++) send_access(OP_LOAD, 64'(i));
    send_access(OP_MODIFY, 64'd1);
    send_access(OP_LOAD, 64'd2);
    in_valid_i <= 0;
    wait_drained();
    // Random phases across settings; the long hold-off fills the queue.
    write_cfg(CFG_SET_BITS, 4'd2);
    write_cfg(CFG_BLOCK_BITS, 4'd4);
    write_cfg(CFG_WAYS, 4'd4);
    long_hold = 1;
    random_phase(100);
    write_cfg(CFG_WAYS, 4'd2);
    random_phase(80);
    write_cfg(CFG_SET_BITS, 4'd6);
    write_cfg(CFG_BLOCK_BITS, 4'd0);
    write_cfg(CFG_WAYS, 4'd8);
    random_phase(100);
    write_cfg(CFG_SET_BITS, 4'd0);
    write_cfg(CFG_WAYS, 4'd1);
    random_phase(60);
    tail_phase = 1;
    write_cfg(CFG_SET_BITS, 4'd3);
    write_cfg(CFG_BLOCK_BITS, 4'd6);
    write_cfg(CFG_WAYS, 4'd3);
    random_phase(90);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

`default_nettype wire

@@ sim.f @@
rtl/salct_pkg.sv
rtl/salct_front.sv
rtl/salct_back.sv
rtl/set_assoc_lru_cache_tracker.sv
sim/tb_top.sv
